// File: src/rgbled_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED effect package
// Shared types and constants for the three-lamp RGB effect generator.
// ----------------------------------------------------------------------------
package rgbled_pkg;

    localparam int CHANNELS        = 9;
    localparam int COLOURS         = 3;
    localparam int OUT_W           = 7;
    localparam int MODE_W          = 3;
    localparam int LEVEL_COUNT_DEF = 128;

    typedef enum logic [MODE_W-1:0] {
        MODE_FADE        = 3'd0,
        MODE_ROUND_BLUE  = 3'd1,
        MODE_ROUND_GREEN = 3'd2,
        MODE_ROUND_RED   = 3'd3,
        MODE_ROUND_MULTI = 3'd4,
        MODE_ALL_BLUE    = 3'd5,
        MODE_ALL_GREEN   = 3'd6,
        MODE_ALL_RED     = 3'd7
    } mode_t;

    typedef logic [CHANNELS-1:0][OUT_W-1:0] frame_t;

endpackage

// File: src/rgb_led_effect_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED effect generator
// Computes one frame of nine PWM levels per input beat for three RGB lamps.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, advance) takes one beat per tick while in_stall is low.
// With advance high the engine steps the selected effect; with advance low it
// only reports the stored levels. Every input beat yields exactly one output
// beat (out_valid, out_stall) carrying the nine lamp levels.
// A result is registered in the result register (or the skid register while
// out_stall holds it); throughput is one beat per cycle while in_stall is low.
// All effect state updates in a single pass of logic at the acceptance edge.
// A two-entry output buffer (result register plus skid register) lets the
// block take a new beat while a result waits; in_stall rises only when both
// entries are full, that is while the skid register holds a result.
// The configuration channel (cfg_valid, cfg_ready, effect_mode) is always
// ready; a write selects the effect and clears the stored levels.
// Reset clears all levels, sets every direction rising, zeroes both round
// indices and selects the fade effect.
// ----------------------------------------------------------------------------
module rgb_led_effect_generator
    import rgbled_pkg::*;
#(
    parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MODE_W-1:0] effect_mode,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              advance,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [OUT_W-1:0]  lamp0_blue,
    output logic [OUT_W-1:0]  lamp0_green,
    output logic [OUT_W-1:0]  lamp0_red,
    output logic [OUT_W-1:0]  lamp1_blue,
    output logic [OUT_W-1:0]  lamp1_green,
    output logic [OUT_W-1:0]  lamp1_red,
    output logic [OUT_W-1:0]  lamp2_blue,
    output logic [OUT_W-1:0]  lamp2_green,
    output logic [OUT_W-1:0]  lamp2_red
);

    localparam int LW = $clog2(LEVEL_COUNT);
    localparam logic [LW-1:0] FULL = LW'(LEVEL_COUNT - 1);
    localparam logic [LW-1:0] HALF = LW'(LEVEL_COUNT / 2 - 1);

    mode_t                  mode_reg;
    logic [CHANNELS-1:0][LW-1:0] level_reg, level_next;
    logic [CHANNELS-1:0]    rising_reg, rising_next;
    logic [1:0]             lamp_reg, lamp_next;
    logic [1:0]             colour_reg, colour_next;

    frame_t                 out_frame_reg, out_frame_next;
    frame_t                 skid_frame_reg, skid_frame_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   skid_valid_reg, skid_valid_next;

    frame_t                 frame;
    logic                   accept;
    logic                   all_zero;
    logic [LW-1:0]          base_level;
    logic                   dir;
    logic [1:0]             round_colour;
    logic [1:0]             all_colour;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        level_next   = level_reg;
        rising_next  = rising_reg;
        lamp_next    = lamp_reg;
        colour_next  = colour_reg;
        frame        = '0;
        all_zero     = (level_reg == '0);
        base_level   = '0;
        dir          = 1'b0;
        round_colour = colour_reg;
        all_colour   = 2'(mode_reg - MODE_ALL_BLUE);

        for (int i = 0; i < CHANNELS; i++)
        begin
            frame[i] = OUT_W'(level_reg[i]);
        end

        if (advance)
        begin
            case (mode_reg)
                MODE_FADE:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (all_zero)
                        begin
                            case ((i % COLOURS + COLOURS - i / COLOURS) % COLOURS)
                                0:       base_level = FULL;
                                1:       base_level = HALF;
                                default: base_level = '0;
                            endcase
                        end
                        else
                        begin
                            base_level = level_reg[i];
                        end
                        dir = all_zero ? 1'b1 : rising_reg[i];
                        if (base_level == '0)
                        begin
                            dir = 1'b1;
                        end
                        else if (base_level >= FULL)
                        begin
                            dir = 1'b0;
                        end
                        rising_next[i] = dir;
                        level_next[i]  = dir ? base_level + 1'b1 : base_level - 1'b1;
                        frame[i]       = OUT_W'(level_next[i]);
                    end
                end
                MODE_ROUND_BLUE, MODE_ROUND_GREEN, MODE_ROUND_RED, MODE_ROUND_MULTI:
                begin
                    if (mode_reg != MODE_ROUND_MULTI)
                    begin
                        round_colour = 2'(mode_reg - MODE_ROUND_BLUE);
                    end
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        frame[i] = (2'(i / COLOURS) == lamp_reg && 2'(i % COLOURS) == round_colour)
                                   ? OUT_W'(FULL) : '0;
                    end
                    lamp_next   = (lamp_reg == 2'd2) ? 2'd0 : lamp_reg + 2'd1;
                    colour_next = (round_colour == 2'd2) ? 2'd0 : round_colour + 2'd1;
                    level_next  = '0;
                end
                default:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        frame[i] = (2'(i % COLOURS) == all_colour) ? OUT_W'(HALF) : '0;
                    end
                    level_next = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_frame_next  = out_frame_reg;
        skid_frame_next = skid_frame_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_frame_next  = skid_frame_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_frame_next = frame;
                out_valid_next = accept;
            end
        end
        else if (accept)
        begin
            skid_frame_next = frame;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_FADE;
            level_reg      <= '0;
            rising_reg     <= '1;
            lamp_reg       <= 2'd0;
            colour_reg     <= 2'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg  <= mode_t'(effect_mode);
                level_reg <= '0;
            end
            else if (accept)
            begin
                level_reg  <= level_next;
                rising_reg <= rising_next;
                lamp_reg   <= lamp_next;
                colour_reg <= colour_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_frame_reg  <= out_frame_next;
        skid_frame_reg <= skid_frame_next;
    end

    assign out_valid   = out_valid_reg;
    assign lamp0_blue  = out_frame_reg[0];
    assign lamp0_green = out_frame_reg[1];
    assign lamp0_red   = out_frame_reg[2];
    assign lamp1_blue  = out_frame_reg[3];
    assign lamp1_green = out_frame_reg[4];
    assign lamp1_red   = out_frame_reg[5];
    assign lamp2_blue  = out_frame_reg[6];
    assign lamp2_green = out_frame_reg[7];
    assign lamp2_red   = out_frame_reg[8];

endmodule

// File: test/rgb_led_effect_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED effect generator testbench
// Walks a short table of directed beats through every effect mode, then runs
// random phases of fade, round and all effects with bursty input and a
// patterned output stall. Each result beat is checked field by field against a
// directed row's golden frame or a behavioral predictor kept in step with accepted beats.
// ----------------------------------------------------------------------------
module rgb_led_effect_generator_test;
    import rgbled_pkg::*;

    localparam logic [OUT_W-1:0] FULL = OUT_W'(LEVEL_COUNT_DEF - 1);
    localparam logic [OUT_W-1:0] HALF = OUT_W'(LEVEL_COUNT_DEF / 2 - 1);
    localparam int RANDOM_BEATS = 930;
    localparam int HOLD_CYCLES  = 100;
    localparam int HOLD_AFTER   = 250;

    typedef enum int { GOLD_PREDICT, GOLD_ZERO, GOLD_FULL_AT, GOLD_HALF_COLOUR } golden_t;

    typedef struct {
        bit      do_write;
        mode_t   mode;
        bit      adv;
        golden_t golden;
        int      chan;
    } plan_row_t;

    localparam int PLAN_ROWS = 21;

    plan_row_t plan [PLAN_ROWS] = '{
        '{1'b0, MODE_FADE,        1'b0, GOLD_ZERO,        0},
        '{1'b0, MODE_FADE,        1'b1, GOLD_PREDICT,     0},
        '{1'b0, MODE_FADE,        1'b1, GOLD_PREDICT,     0},
        '{1'b0, MODE_FADE,        1'b0, GOLD_PREDICT,     0},
        '{1'b1, MODE_FADE,        1'b0, GOLD_ZERO,        0},
        '{1'b0, MODE_FADE,        1'b1, GOLD_PREDICT,     0},
        '{1'b1, MODE_ROUND_BLUE,  1'b1, GOLD_FULL_AT,     0},
        '{1'b0, MODE_ROUND_BLUE,  1'b1, GOLD_PREDICT,     0},
        '{1'b0, MODE_ROUND_BLUE,  1'b1, GOLD_PREDICT,     0},
        '{1'b0, MODE_ROUND_BLUE,  1'b0, GOLD_ZERO,        0},
        '{1'b1, MODE_ROUND_GREEN, 1'b1, GOLD_PREDICT,     0},
        '{1'b1, MODE_ROUND_RED,   1'b1, GOLD_PREDICT,     0},
        '{1'b1, MODE_ROUND_MULTI, 1'b1, GOLD_PREDICT,     0},
        '{1'b0, MODE_ROUND_MULTI, 1'b1, GOLD_PREDICT,     0},
        '{1'b0, MODE_ROUND_MULTI, 1'b1, GOLD_PREDICT,     0},
        '{1'b1, MODE_ALL_BLUE,    1'b1, GOLD_HALF_COLOUR, 0},
        '{1'b1, MODE_ALL_GREEN,   1'b1, GOLD_HALF_COLOUR, 1},
        '{1'b1, MODE_ALL_RED,     1'b1, GOLD_HALF_COLOUR, 2},
        '{1'b0, MODE_ALL_RED,     1'b0, GOLD_ZERO,        0},
        '{1'b1, MODE_FADE,        1'b1, GOLD_PREDICT,     0},
        '{1'b0, MODE_FADE,        1'b1, GOLD_PREDICT,     0}
    };

    string chan_name [CHANNELS] = '{
        "lamp0_blue", "lamp0_green", "lamp0_red",
        "lamp1_blue", "lamp1_green", "lamp1_red",
        "lamp2_blue", "lamp2_green", "lamp2_red"
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [MODE_W-1:0] effect_mode = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              advance = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [OUT_W-1:0]  lamp0_blue, lamp0_green, lamp0_red;
    logic [OUT_W-1:0]  lamp1_blue, lamp1_green, lamp1_red;
    logic [OUT_W-1:0]  lamp2_blue, lamp2_green, lamp2_red;

    logic [OUT_W-1:0] level_q [CHANNELS];
    bit               rising_q [CHANNELS];
    logic [1:0]       lamp_q;
    logic [1:0]       colour_q;
    mode_t            mode_q;

    frame_t expected_frames [$];
    int     mismatches;
    int     beats_sent;
    int     frames_seen;
    int     mode_writes;
    int     input_stalls;
    int     burst_left;
    int     hold_left;
    bit     hold_done;
    bit     sender_busy;
    bit     fade_hit_full;
    bit     fade_hit_zero;

    rgb_led_effect_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .effect_mode (effect_mode),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .lamp0_blue  (lamp0_blue),
        .lamp0_green (lamp0_green),
        .lamp0_red   (lamp0_red),
        .lamp1_blue  (lamp1_blue),
        .lamp1_green (lamp1_green),
        .lamp1_red   (lamp1_red),
        .lamp2_blue  (lamp2_blue),
        .lamp2_green (lamp2_green),
        .lamp2_red   (lamp2_red)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic frame_t next_frame(bit adv);
        frame_t f;
        bit     all_zero;
        int     colour;
        f = '0;
        if (!adv)
        begin
            for (int i = 0; i < CHANNELS; i++)
                f[i] = level_q[i];
        end
        else if (mode_q == MODE_FADE)
        begin
            all_zero = 1'b1;
            for (int i = 0; i < CHANNELS; i++)
                if (level_q[i] != '0)
                    all_zero = 1'b0;
            if (all_zero)
            begin
                level_q = '{FULL, HALF, '0, '0, FULL, HALF, HALF, '0, FULL};
                for (int i = 0; i < CHANNELS; i++)
                    rising_q[i] = 1'b1;
            end
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (level_q[i] == '0)
                    rising_q[i] = 1'b1;
                else if (level_q[i] >= FULL)
                    rising_q[i] = 1'b0;
                level_q[i] = rising_q[i] ? level_q[i] + 1'b1 : level_q[i] - 1'b1;
                if (level_q[i] == FULL)
                    fade_hit_full = 1'b1;
                if (level_q[i] == '0)
                    fade_hit_zero = 1'b1;
                f[i] = level_q[i];
            end
        end
        else if (mode_q <= MODE_ROUND_MULTI)
        begin
            if (mode_q != MODE_ROUND_MULTI)
                colour_q = 2'(int'(mode_q) - int'(MODE_ROUND_BLUE));
            if (lamp_q > 2'd2)
                lamp_q = 2'd0;
            if (colour_q > 2'd2)
                colour_q = 2'd0;
            f[int'(lamp_q) * COLOURS + int'(colour_q)] = FULL;
            lamp_q   = (lamp_q == 2'd2) ? 2'd0 : lamp_q + 2'd1;
            colour_q = (colour_q == 2'd2) ? 2'd0 : colour_q + 2'd1;
            for (int i = 0; i < CHANNELS; i++)
                level_q[i] = '0;
        end
        else
        begin
            colour = int'(mode_q) - int'(MODE_ALL_BLUE);
            for (int i = 0; i < CHANNELS; i++)
                f[i] = (i % COLOURS == colour) ? HALF : '0;
            for (int i = 0; i < CHANNELS; i++)
                level_q[i] = '0;
        end
        return f;
    endfunction

    function automatic frame_t golden_frame(golden_t kind, int chan);
        frame_t f;
        f = '0;
        if (kind == GOLD_FULL_AT)
            f[chan] = FULL;
        else if (kind == GOLD_HALF_COLOUR)
            for (int i = 0; i < CHANNELS; i++)
                if (i % COLOURS == chan)
                    f[i] = HALF;
        return f;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_beat(input bit adv, input bit use_gold, input frame_t gold);
        frame_t predicted;
        int     gap;
        in_valid    <= 1'b1;
        advance     <= adv;
        sender_busy = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = next_frame(adv);
        expected_frames.push_back(use_gold ? gold : predicted);
        beats_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0 && hold_left == 0)
            begin
                in_valid    <= 1'b0;
                advance     <= 1'($urandom);
                sender_busy = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_mode(input mode_t m);
        if (sender_busy)
        begin
            in_valid    <= 1'b0;
            advance     <= 1'($urandom);
            sender_busy = 1'b0;
        end
        while (expected_frames.size() > 0)
            @(posedge clk);
        @(posedge clk);
        cfg_valid   <= 1'b1;
        effect_mode <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_q = m;
        for (int i = 0; i < CHANNELS; i++)
            level_q[i] = '0;
        mode_writes++;
    endtask

    initial
    begin
        int     seg_left;
        int     style;
        seg_left = 0;
        style    = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (!hold_done && frames_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(5, 60);
                    style    = $urandom_range(0, 3);
                end
                seg_left--;
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 2) == 0);
                    2:       out_stall <= ~out_stall;
                    default: out_stall <= ($urandom_range(0, 2) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        frame_t got;
        frame_t want;
        if (rst_n)
        begin
            if (in_valid && in_stall)
                input_stalls++;
            if (out_valid && !out_stall)
            begin
                got = {lamp2_red, lamp2_green, lamp2_blue,
                       lamp1_red, lamp1_green, lamp1_blue,
                       lamp0_red, lamp0_green, lamp0_blue};
                frames_seen++;
                if (expected_frames.size() == 0)
                    report_mismatch("result beat with no expected frame");
                else
                begin
                    want = expected_frames.pop_front();
                    for (int i = 0; i < CHANNELS; i++)
                        if (got[i] !== want[i])
                            report_mismatch($sformatf("frame %0d %s got %0d expected %0d",
                                frames_seen, chan_name[i], got[i], want[i]));
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d frames still expected", expected_frames.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int    len;
        int    target;
        mode_t pick;
        for (int i = 0; i < CHANNELS; i++)
        begin
            level_q[i]  = '0;
            rising_q[i] = 1'b1;
        end
        lamp_q   = 2'd0;
        colour_q = 2'd0;
        mode_q   = MODE_FADE;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].do_write)
                write_mode(plan[r].mode);
            send_beat(plan[r].adv, plan[r].golden != GOLD_PREDICT,
                      golden_frame(plan[r].golden, plan[r].chan));
        end

        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                pick = ($urandom_range(0, 9) < 4) ? MODE_FADE : mode_t'($urandom_range(0, 7));
                write_mode(pick);
            end
            len = (mode_q == MODE_FADE) ? $urandom_range(60, 260) : $urandom_range(8, 60);
            for (int k = 0; k < len && beats_sent < target; k++)
                send_beat($urandom_range(0, 99) < ((mode_q == MODE_FADE) ? 88 : 75), 1'b0, '0);
        end

        if (sender_busy)
        begin
            in_valid    <= 1'b0;
            sender_busy = 1'b0;
        end
        while (expected_frames.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d input beats, %0d result beats, %0d mode writes",
                 beats_sent, frames_seen, mode_writes);
        $display("input held off on %0d cycles; fade reached full %0d and zero %0d",
                 input_stalls, fade_hit_full, fade_hit_zero);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
src/rgbled_pkg.sv
src/rgb_led_effect_generator.sv
test/rgb_led_effect_generator_test.sv
